// ===== hw/rtl/dqp_pkg.sv =====
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and constants of the DNS question parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dqp_pkg;

  localparam int unsigned MAX_NAME_BYTES_DEF = 255;

  localparam logic [3:0] HDR_FLAGS_IDX = 4'd2;
  localparam logic [3:0] HDR_QD_HI_IDX = 4'd4;
  localparam logic [3:0] HDR_QD_LO_IDX = 4'd5;
  localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
  localparam int unsigned RESP_BIT     = 7;

  localparam logic [7:0]  LABEL_MAX   = 8'd63;
  localparam logic [15:0] QD_ONE      = 16'd1;
  localparam logic [15:0] QCLASS_INET = 16'd1;

  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UZ     = 8'h5A;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CASE_OFFSET = CHAR_LA - CHAR_UA;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_LEN      = 3'd1,
    PH_CHARS    = 3'd2,
    PH_TYPE_HI  = 3'd3,
    PH_TYPE_LO  = 3'd4,
    PH_CLASS_HI = 3'd5,
    PH_CLASS_LO = 3'd6,
    PH_SKIP     = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESPONSE  = 3'd1,
    ST_QDCOUNT   = 3'd2,
    ST_CLASS     = 3'd3,
    ST_MALFORMED = 3'd4
  } status_e;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  name_char;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [7:0]  name_length;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dqp_if.sv =====
// ----------------------------------------------------------------------------
// dqp_byte_if / dqp_result_if
// Valid/ready channels for packet bytes and parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface dqp_result_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [7:0]  name_char;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [7:0]  name_length;
  logic [2:0]  status;

  modport source (output valid, output is_summary, output name_char, output query_type,
                  output query_class, output name_length, output status, input ready);
  modport sink   (input valid, input is_summary, input name_char, input query_type,
                  input query_class, input name_length, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dqp_step.sv =====
// ----------------------------------------------------------------------------
// dqp_step
// Parse state registers and the per-byte update that yields at most one item.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_step #(
  parameter int unsigned MAX_NAME_BYTES = dqp_pkg::MAX_NAME_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       packet_byte_i,
  input  wire logic             last_byte_i,
  output      logic             emit_o,
  output      dqp_pkg::result_t result_o
);

  dqp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic [5:0]  label_left_q, label_left_d;
  logic [7:0]  name_count_q, name_count_d;
  logic        seen_label_q, seen_label_d;
  logic        resp_q, resp_d;
  logic [15:0] qd_count_q, qd_count_d;
  logic [15:0] type_q, type_d;
  logic [7:0]  class_hi_q, class_hi_d;
  logic        sent_q, sent_d;

  logic             emit;
  logic             sum_now;
  dqp_pkg::status_e status;
  logic [7:0]       out_char;
  logic [15:0]      out_type;
  logic [15:0]      out_class;
  logic [7:0]       low_char;
  logic [15:0]      class_full;
  logic             name_full;

  assign name_full  = name_count_q >= 8'(MAX_NAME_BYTES);
  assign class_full = {class_hi_q, packet_byte_i};
  assign low_char   = (packet_byte_i >= dqp_pkg::CHAR_UA && packet_byte_i <= dqp_pkg::CHAR_UZ)
                    ? packet_byte_i + dqp_pkg::CASE_OFFSET : packet_byte_i;

  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    label_left_d = label_left_q;
    name_count_d = name_count_q;
    seen_label_d = seen_label_q;
    resp_d       = resp_q;
    qd_count_d   = qd_count_q;
    type_d       = type_q;
    class_hi_d   = class_hi_q;
    sent_d       = sent_q;
    emit         = 1'b0;
    sum_now      = 1'b0;
    status       = dqp_pkg::ST_OK;
    out_char     = '0;
    out_type     = '0;
    out_class    = '0;

    case (phase_q)
      dqp_pkg::PH_HEADER: begin
        if (hdr_idx_q == dqp_pkg::HDR_FLAGS_IDX) begin
          resp_d = packet_byte_i[dqp_pkg::RESP_BIT];
        end else if (hdr_idx_q == dqp_pkg::HDR_QD_HI_IDX) begin
          qd_count_d = {packet_byte_i, qd_count_q[7:0]};
        end else if (hdr_idx_q == dqp_pkg::HDR_QD_LO_IDX) begin
          qd_count_d = {qd_count_q[15:8], packet_byte_i};
        end
        if (hdr_idx_q >= dqp_pkg::HDR_LAST_IDX) begin
          hdr_idx_d = '0;
          if (resp_q) begin
            emit    = 1'b1;
            sum_now = 1'b1;
            status  = dqp_pkg::ST_RESPONSE;
          end else if (qd_count_q != dqp_pkg::QD_ONE) begin
            emit    = 1'b1;
            sum_now = 1'b1;
            status  = dqp_pkg::ST_QDCOUNT;
          end else begin
            phase_d = dqp_pkg::PH_LEN;
          end
        end else begin
          hdr_idx_d = hdr_idx_q + 4'd1;
        end
      end
      dqp_pkg::PH_LEN: begin
        if (packet_byte_i == '0) begin
          phase_d = dqp_pkg::PH_TYPE_HI;
        end else if (packet_byte_i > dqp_pkg::LABEL_MAX) begin
          emit    = 1'b1;
          sum_now = 1'b1;
          status  = dqp_pkg::ST_MALFORMED;
        end else begin
          label_left_d = packet_byte_i[5:0];
          phase_d      = dqp_pkg::PH_CHARS;
          seen_label_d = 1'b1;
          if (seen_label_q) begin
            emit = 1'b1;
            if (name_full) begin
              sum_now = 1'b1;
              status  = dqp_pkg::ST_MALFORMED;
            end else begin
              name_count_d = name_count_q + 8'd1;
              out_char     = dqp_pkg::CHAR_DOT;
            end
          end
        end
      end
      dqp_pkg::PH_CHARS: begin
        emit = 1'b1;
        if (name_full) begin
          sum_now = 1'b1;
          status  = dqp_pkg::ST_MALFORMED;
        end else begin
          name_count_d = name_count_q + 8'd1;
          out_char     = low_char;
          label_left_d = label_left_q - 6'd1;
          if (label_left_q == 6'd1) begin
            phase_d = dqp_pkg::PH_LEN;
          end
        end
      end
      dqp_pkg::PH_TYPE_HI: begin
        type_d  = {packet_byte_i, 8'h00};
        phase_d = dqp_pkg::PH_TYPE_LO;
      end
      dqp_pkg::PH_TYPE_LO: begin
        type_d  = {type_q[15:8], packet_byte_i};
        phase_d = dqp_pkg::PH_CLASS_HI;
      end
      dqp_pkg::PH_CLASS_HI: begin
        class_hi_d = packet_byte_i;
        phase_d    = dqp_pkg::PH_CLASS_LO;
      end
      dqp_pkg::PH_CLASS_LO: begin
        emit      = 1'b1;
        sum_now   = 1'b1;
        status    = (class_full == dqp_pkg::QCLASS_INET) ? dqp_pkg::ST_OK : dqp_pkg::ST_CLASS;
        out_type  = type_q;
        out_class = class_full;
      end
      default: begin
      end
    endcase

    // truncated packet: replace this byte's result with a malformed summary
    if (last_byte_i && !sent_q && !(emit && sum_now)) begin
      emit      = 1'b1;
      sum_now   = 1'b1;
      status    = dqp_pkg::ST_MALFORMED;
      out_char  = '0;
      out_type  = '0;
      out_class = '0;
    end

    if (sum_now) begin
      sent_d  = 1'b1;
      phase_d = dqp_pkg::PH_SKIP;
    end
  end

  always_comb begin
    result_o.is_summary  = sum_now;
    result_o.name_char   = sum_now ? 8'h00 : out_char;
    result_o.query_type  = out_type;
    result_o.query_class = out_class;
    result_o.name_length = sum_now ? name_count_d : 8'h00;
    result_o.status      = sum_now ? status : dqp_pkg::ST_OK;
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dqp_pkg::PH_HEADER;
      hdr_idx_q    <= '0;
      label_left_q <= '0;
      name_count_q <= '0;
      seen_label_q <= 1'b0;
      resp_q       <= 1'b0;
      qd_count_q   <= '0;
      type_q       <= '0;
      class_hi_q   <= '0;
      sent_q       <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q      <= dqp_pkg::PH_HEADER;
        hdr_idx_q    <= '0;
        label_left_q <= '0;
        name_count_q <= '0;
        seen_label_q <= 1'b0;
        resp_q       <= 1'b0;
        qd_count_q   <= '0;
        type_q       <= '0;
        class_hi_q   <= '0;
        sent_q       <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        hdr_idx_q    <= hdr_idx_d;
        label_left_q <= label_left_d;
        name_count_q <= name_count_d;
        seen_label_q <= seen_label_d;
        resp_q       <= resp_d;
        qd_count_q   <= qd_count_d;
        type_q       <= type_d;
        class_hi_q   <= class_hi_d;
        sent_q       <= sent_d;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (phase_q == dqp_pkg::PH_HEADER && name_count_q == '0
                                   && !sent_q))
    else $error("state not cleared after final byte");

  a_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_count_q <= 8'(MAX_NAME_BYTES))
    else $error("name count beyond limit");

  a_sent_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> (phase_q == dqp_pkg::PH_SKIP))
    else $error("summary sent but parser still active");

  a_summary_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && emit && sum_now && !last_byte_i) |=> (sent_q && phase_q == dqp_pkg::PH_SKIP))
    else $error("summary did not end the question");

endmodule

`default_nettype wire

// ===== hw/rtl/dqp_out_reg.sv =====
// ----------------------------------------------------------------------------
// dqp_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dqp_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire dqp_pkg::result_t result_i,
  output      logic             space_o,
  dqp_result_if.source          result_o
);

  logic             valid_q, valid_d;
  dqp_pkg::result_t data_q;

  assign space_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.is_summary  = data_q.is_summary;
  assign result_o.name_char   = data_q.name_char;
  assign result_o.query_type  = data_q.query_type;
  assign result_o.query_class = data_q.query_class;
  assign result_o.name_length = data_q.name_length;
  assign result_o.status      = data_q.status;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !result_o.ready) |=> (valid_q && $stable(data_q)))
    else $error("stalled result overwritten");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (space_o && load_i) |=> valid_q)
    else $error("loaded result not presented");

  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (space_o && !load_i) |=> !valid_q)
    else $error("result presented without a load");

endmodule

`default_nettype wire

// ===== hw/rtl/dns_question_parser_top.sv =====
// ----------------------------------------------------------------------------
// dns_question_parser_top
// DNS query question parser: bytes in, name characters and a summary out.
//
// byte_i carries the packet one byte per item, header first, with last_byte
// set on the final byte. result_o carries one item per name character
// (lower case, dots between labels) and one summary item per packet with
// the query type, class, name length and status.
// Each accepted byte is parsed in the cycle it is accepted; its result, if
// any, is presented from the result register on the next cycle, and a byte
// can be accepted every cycle while no stalled result is held. The parse
// update is combinational and feeds the result register directly.
// byte_i.ready is low only while a result is held and result_o.ready is low;
// a stalled result stays unchanged and no byte is taken until it leaves.
// Reset clears all parse state to the start of a fresh packet and empties
// the result register; a byte can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_question_parser_top #(
  parameter int unsigned MAX_NAME_BYTES = dqp_pkg::MAX_NAME_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  dqp_byte_if.sink      byte_i,
  dqp_result_if.source  result_o
);

  logic             space;
  logic             accept;
  logic             emit;
  dqp_pkg::result_t step_result;

  assign byte_i.ready = space;
  assign accept       = byte_i.valid && space;

  dqp_step #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .packet_byte_i (byte_i.packet_byte),
    .last_byte_i   (byte_i.last_byte),
    .emit_o        (emit),
    .result_o      (step_result)
  );

  dqp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept && emit),
    .result_i (step_result),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/dqp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dqp_tb_pkg
// Scoreboard of the DNS question parser testbench. It parses every accepted
// packet byte itself, queues the name characters and summaries that are due,
// and checks each item leaving the block against the oldest one.
// ----------------------------------------------------------------------------
package dqp_tb_pkg;

  import dqp_pkg::*;

  class question_scoreboard;

    phase_e      phase;
    logic [3:0]  header_pos;
    logic [5:0]  label_left;
    logic [7:0]  name_count;
    bit          seen_label;
    bit          response_seen;
    bit          summary_done;
    logic [15:0] qd_count;
    logic [15:0] qtype;
    logic [7:0]  class_hi;

    result_t     results_due[$];
    int unsigned mismatches;

    function new();
      clear_parse();
      mismatches = 0;
    endfunction

    function void clear_parse();
      phase         = PH_HEADER;
      header_pos    = '0;
      label_left    = '0;
      name_count    = '0;
      seen_label    = 1'b0;
      response_seen = 1'b0;
      summary_done  = 1'b0;
      qd_count      = '0;
      qtype         = '0;
      class_hi      = '0;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function result_t summary(status_e st, logic [15:0] qt, logic [15:0] qc);
      result_t r;
      r             = '0;
      r.is_summary  = 1'b1;
      r.query_type  = qt;
      r.query_class = qc;
      r.name_length = name_count;
      r.status      = st;
      summary_done  = 1'b1;
      phase         = PH_SKIP;
      return r;
    endfunction

    // Give a malformed summary in place of a character that overflows the name.
    function result_t name_item(logic [7:0] c);
      result_t r;
      if (name_count >= MAX_NAME_BYTES_DEF) return summary(ST_MALFORMED, '0, '0);
      name_count  = name_count + 8'd1;
      r           = '0;
      r.name_char = c;
      return r;
    endfunction

    function void parse_byte(logic [7:0] b, logic last);
      result_t     r;
      logic [7:0]  c;
      logic [15:0] qc;
      bit          emitted;
      bit          complete;
      r        = '0;
      emitted  = 1'b0;
      complete = 1'b0;
      case (phase)
        PH_HEADER: begin
          if (header_pos == HDR_FLAGS_IDX) response_seen = b[RESP_BIT];
          else if (header_pos == HDR_QD_HI_IDX) qd_count[15:8] = b;
          else if (header_pos == HDR_QD_LO_IDX) qd_count[7:0] = b;
          if (header_pos >= HDR_LAST_IDX) begin
            header_pos = '0;
            if (response_seen) begin
              r        = summary(ST_RESPONSE, '0, '0);
              emitted  = 1'b1;
              complete = 1'b1;
            end else if (qd_count != QD_ONE) begin
              r        = summary(ST_QDCOUNT, '0, '0);
              emitted  = 1'b1;
              complete = 1'b1;
            end else begin
              phase = PH_LEN;
            end
          end else begin
            header_pos = header_pos + 4'd1;
          end
        end
        PH_LEN: begin
          if (b == 8'd0) begin
            phase = PH_TYPE_HI;
          end else if (b > LABEL_MAX) begin
            r       = summary(ST_MALFORMED, '0, '0);
            emitted = 1'b1;
          end else begin
            label_left = b[5:0];
            phase      = PH_CHARS;
            if (seen_label) begin
              r       = name_item(CHAR_DOT);
              emitted = 1'b1;
            end
            seen_label = 1'b1;
          end
        end
        PH_CHARS: begin
          c = b;
          if (c >= CHAR_UA && c <= CHAR_UZ) c = c + CASE_OFFSET;
          r       = name_item(c);
          emitted = 1'b1;
          if (phase == PH_CHARS) begin
            label_left = label_left - 6'd1;
            if (label_left == 6'd0) phase = PH_LEN;
          end
        end
        PH_TYPE_HI: begin
          qtype = {b, 8'h00};
          phase = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          qtype[7:0] = b;
          phase      = PH_CLASS_HI;
        end
        PH_CLASS_HI: begin
          class_hi = b;
          phase    = PH_CLASS_LO;
        end
        PH_CLASS_LO: begin
          qc       = {class_hi, b};
          r        = summary((qc == QCLASS_INET) ? ST_OK : ST_CLASS, qtype, qc);
          emitted  = 1'b1;
          complete = 1'b1;
        end
        default: ;
      endcase
      if (last) begin
        if (!complete && !(emitted && r.is_summary) && !(summary_done && !emitted)) begin
          r       = summary(ST_MALFORMED, '0, '0);
          emitted = 1'b1;
        end
        clear_parse();
      end
      if (emitted) results_due.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $error("result with nothing due: is_summary %0d name_char %0h status %0d",
               got.is_summary, got.name_char, got.status);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (got.is_summary !== want.is_summary) begin
        $error("is_summary: expected %0d, actual %0d", want.is_summary, got.is_summary);
        mismatches++;
      end
      if (got.name_char !== want.name_char) begin
        $error("name_char: expected %0h, actual %0h", want.name_char, got.name_char);
        mismatches++;
      end
      if (got.query_type !== want.query_type) begin
        $error("query_type: expected %0h, actual %0h", want.query_type, got.query_type);
        mismatches++;
      end
      if (got.query_class !== want.query_class) begin
        $error("query_class: expected %0h, actual %0h", want.query_class, got.query_class);
        mismatches++;
      end
      if (got.name_length !== want.name_length) begin
        $error("name_length: expected %0d, actual %0d", want.name_length, got.name_length);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ===== tb/sv/tb_dns_question_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_dns_question_parser_top
// Drives DNS query packets into the question parser with random gaps and
// result back-pressure: a few directed packets first, then random well-formed
// queries mixed with response, question count, label length, truncated,
// over-long name and noise packets. Every result item is checked against the
// scoreboard's own parse of the accepted bytes.
// ----------------------------------------------------------------------------
module tb_dns_question_parser_top;

  timeunit 1ns;
  timeprecision 1ps;

  import dqp_pkg::*;
  import dqp_tb_pkg::*;

  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned RANDOM_BYTES = 400;

  logic clk_i;
  logic rst_ni;

  dqp_byte_if   byte_if();
  dqp_result_if result_if();

  dns_question_parser_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  question_scoreboard sb;
  logic [7:0]         pkt_q[$];
  bit                 tx_idle_on;
  bit                 rx_idle_on;
  bit                 rx_long_hold;
  int unsigned        bytes_sent;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.packet_byte <= b;
    byte_if.last_byte   <= last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sb.parse_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    bytes_sent += pkt_q.size();
    pkt_q.delete();
  endtask

  // Hold the input idle until every result due has left the block.
  task automatic drain();
    byte_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic void add_header(logic resp, logic [15:0] qd);
    logic [7:0] b;
    for (int i = 0; i <= HDR_LAST_IDX; i++) begin
      b = 8'($urandom());
      if (i == HDR_FLAGS_IDX) b[RESP_BIT] = resp;
      if (i == HDR_QD_HI_IDX) b = qd[15:8];
      if (i == HDR_QD_LO_IDX) b = qd[7:0];
      pkt_q.push_back(b);
    end
  endfunction

  function automatic logic [7:0] name_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom());
      1: return 8'($urandom_range(CHAR_UA, CHAR_UZ));
      2: return 8'($urandom_range(CHAR_LA, CHAR_LA + 8'd25));
      default: begin
        case ($urandom_range(0, 5))
          0: return CHAR_UA - 8'd1;
          1: return CHAR_UZ + 8'd1;
          2: return CHAR_LA - 8'd1;
          3: return CHAR_LA + 8'd26;
          4: return CHAR_UA;
          default: return CHAR_UZ;
        endcase
      end
    endcase
  endfunction

  function automatic void add_label(int unsigned len);
    pkt_q.push_back(len[7:0]);
    repeat (len) pkt_q.push_back(name_byte());
  endfunction

  function automatic void add_tail();
    logic [15:0] qc;
    qc = ($urandom_range(0, 3) != 0) ? QCLASS_INET : 16'($urandom());
    pkt_q.push_back(8'($urandom()));
    pkt_q.push_back(8'($urandom()));
    pkt_q.push_back(qc[15:8]);
    pkt_q.push_back(qc[7:0]);
    repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom()));
  endfunction

  function automatic void add_question(int unsigned labels);
    int unsigned max_len;
    max_len = ($urandom_range(0, 7) == 0) ? LABEL_MAX : 8;
    repeat (labels) add_label($urandom_range(1, max_len));
    pkt_q.push_back(8'h00);
    add_tail();
  endfunction

  initial begin
    logic [15:0] qd;
    int unsigned kind;
    int unsigned cut;
    int unsigned pk;
    rst_ni              = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.packet_byte = '0;
    byte_if.last_byte   = 1'b0;
    tx_idle_on          = 1'b1;
    rx_long_hold        = 1'b0;
    bytes_sent          = 0;
    sb                  = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // truncated inside the header
    repeat (3) pkt_q.push_back(8'hFF);
    send_packet();
    // all-ones header: response bit wins over the question count
    repeat (HDR_LAST_IDX + 1) pkt_q.push_back(8'hFF);
    send_packet();
    // empty name, extreme type, class IN ending on the last byte
    repeat (HDR_LAST_IDX + 1) pkt_q.push_back(8'h00);
    pkt_q[HDR_QD_LO_IDX] = 8'h01;
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(8'hFF);
    pkt_q.push_back(QCLASS_INET[15:8]);
    pkt_q.push_back(QCLASS_INET[7:0]);
    send_packet();

    bytes_sent = 0;
    pk         = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      kind       = (pk == 2) ? 0 : $urandom_range(0, 15);
      if (pk == 1) begin
        // four full labels fill the name; a fifth overflows it on its dot
        add_header(1'b0, QD_ONE);
        repeat (4) add_label(LABEL_MAX);
        if ($urandom_range(0, 1) != 0) add_label($urandom_range(1, LABEL_MAX));
        pkt_q.push_back(8'h00);
        add_tail();
      end else if (kind <= 8) begin
        add_header(1'b0, QD_ONE);
        add_question((pk == 2) ? 3 : $urandom_range(0, 4));
      end else if (kind == 9) begin
        add_header(1'b1, 16'($urandom()));
        add_question($urandom_range(0, 2));
      end else if (kind == 10) begin
        case ($urandom_range(0, 3))
          0: qd = 16'h0000;
          1: qd = 16'h0002;
          2: qd = 16'hFFFF;
          default: qd = 16'($urandom());
        endcase
        if (qd == QD_ONE) qd = 16'h0000;
        add_header(1'b0, qd);
        add_question($urandom_range(0, 2));
      end else if (kind == 11) begin
        add_header(1'b0, QD_ONE);
        if ($urandom_range(0, 1) != 0) add_label($urandom_range(1, 8));
        pkt_q.push_back(8'($urandom_range(LABEL_MAX + 1, 255)));
        repeat ($urandom_range(0, 6)) pkt_q.push_back(8'($urandom()));
      end else if (kind <= 14) begin
        add_header(1'b0, QD_ONE);
        add_question($urandom_range(0, 3));
        cut = $urandom_range(1, pkt_q.size() - 1);
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end else begin
        repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom()));
      end
      if (pk == 2) begin
        tx_idle_on   = 1'b0;
        rx_long_hold = 1'b1;
      end
      send_packet();
      if (pk % 12 == 7) drain();
      pk++;
    end

    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    result_t     got;
    result_if.ready = 1'b0;
    rx_idle_on      = 1'b1;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      if (rx_long_hold) begin
        stall        = LONG_HOLD;
        rx_long_hold = 1'b0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      got.is_summary  = result_if.is_summary;
      got.name_char   = result_if.name_char;
      got.query_type  = result_if.query_type;
      got.query_class = result_if.query_class;
      got.name_length = result_if.name_length;
      got.status      = status_e'(result_if.status);
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
